// ===== rtl/faded_sine_tone_burst_top_assert.svh =====
// assertion macros shared by the tone burst rtl
`ifndef FADED_SINE_TONE_BURST_TOP_ASSERT_SVH
`define FADED_SINE_TONE_BURST_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define FST_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fst_pkg.sv =====
// shared types, constants and the sine table function of the tone burst generator
package fst_pkg;

   localparam int DEF_SINE_TABLE_DEPTH = 1024;
   localparam int DEF_FADE_SAMPLES     = 80;

   localparam int AMP_PEAK  = 32000;
   localparam int Q15_PEAK  = 32767;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int MAG_W   = 15;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [11:0] duration_ms;
      logic [6:0]  volume_pct;
   } cfg_type;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_DURATION_MS = 2'd1,
      CSR_VOLUME_PCT  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_IDX,
      ST_AE,
      ST_PS,
      ST_DIV,
      ST_QF,
      ST_FIX
   } seq_state_type;

   // sin(x) in q1.15 for x in q30 radians over the first quarter wave
   function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = (sum >= term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      v = (sum * 64'(Q15_PEAK) + (64'd1 << 29)) >> 30;
      if (v > 64'(Q15_PEAK)) begin
         v = 64'(Q15_PEAK);
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

// ===== rtl/fst_req_if.sv =====
// request channel: one tick beat carrying the start flag
interface fst_req_if;
   logic valid;
   logic ready;
   logic start_req;

   modport source (output valid, output start_req, input ready);
   modport sink (input valid, input start_req, output ready);
endinterface

// ===== rtl/fst_rsp_if.sv =====
// response channel: one audio sample beat
interface fst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               active;
   logic               last;

   modport source (output valid, output sample, output active, output last, input ready);
   modport sink (input valid, input sample, input active, input last, output ready);
endinterface

// ===== rtl/fst_csr_if.sv =====
// register write channel
interface fst_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fst_mul.sv =====
// shared unsigned multiplier with registered product
module fst_mul (
   input  logic                        clock,
   input  logic                        en,
   input  logic [fst_pkg::MUL_A_W-1:0] a,
   input  logic [fst_pkg::MUL_B_W-1:0] b,
   output logic [fst_pkg::MUL_P_W-1:0] p
);

   logic [fst_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= fst_pkg::MUL_P_W'(a) * fst_pkg::MUL_P_W'(b);
      end
   end

   assign p = prod_ff;

endmodule

// ===== rtl/fst_sine_rom.sv =====
// quarter-wave sine magnitude table with registered read
module fst_sine_rom #(
   parameter int  SINE_TABLE_DEPTH = fst_pkg::DEF_SINE_TABLE_DEPTH,
   localparam int QUARTER_LEN      = SINE_TABLE_DEPTH / 4,
   localparam int ROM_AW           = $clog2(QUARTER_LEN + 1)
) (
   input  logic                      clock,
   input  logic [ROM_AW-1:0]         addr,
   output logic [fst_pkg::MAG_W-1:0] mag
);

   logic [fst_pkg::MAG_W-1:0] quarter_rom [QUARTER_LEN+1];
   logic [fst_pkg::MAG_W-1:0] mag_ff;

   for (genvar i = 0; i <= QUARTER_LEN; i++) begin : g_entry
      localparam logic [63:0] X_Q30 = (64'(i) * fst_pkg::PI_HALF_Q30) / QUARTER_LEN;
      assign quarter_rom[i] = fst_pkg::quarter_sine(X_Q30);
   end

   always_ff @(posedge clock) begin
      mag_ff <= quarter_rom[addr];
   end

   assign mag = mag_ff;

endmodule

// ===== rtl/fst_seq.sv =====
// burst sequencer: state, envelope, table lookup and scaling over the shared multiplier
`include "faded_sine_tone_burst_top_assert.svh"

module fst_seq #(
   parameter int SINE_TABLE_DEPTH = fst_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int FADE_SAMPLES     = fst_pkg::DEF_FADE_SAMPLES
) (
   input  logic             clock,
   input  logic             reset,
   input  fst_pkg::cfg_type cfg,
   fst_req_if.sink          req_ch,
   fst_rsp_if.source        rsp_ch
);

   localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int QUARTER_LEN = SINE_TABLE_DEPTH / 4;
   localparam int ROM_AW      = $clog2(QUARTER_LEN + 1);
   localparam int ENV_W       = $clog2(FADE_SAMPLES + 1);
   localparam int PROD_W      = $clog2(fst_pkg::AMP_PEAK * FADE_SAMPLES + 1);
   localparam int RECIP       = (2 ** PROD_W) / FADE_SAMPLES;
   localparam logic [PROD_W-1:0] TWO_FADE = PROD_W'(2 * FADE_SAMPLES);

   fst_pkg::seq_state_type state_ff, state_in;

   logic [15:0]       idx_ff, idx_in;
   logic [31:0]       phase_ff, phase_in;
   logic              run_ff, run_in;
   logic [14:0]       amp_ff, amp_in;
   logic [ENV_W-1:0]  env_ff, env_in;
   logic              last_ff, last_in;
   logic              sign_ff, sign_in;
   logic [PROD_W-1:0] r_ff, r_in;
   logic [15:0]       qest_ff, qest_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       sample_ff, sample_in;
   logic              active_ff, active_in;
   logic              last_out_ff, last_out_in;

   logic                          mul_en;
   logic [fst_pkg::MUL_A_W-1:0]   mul_a;
   logic [fst_pkg::MUL_B_W-1:0]   mul_b;
   logic [fst_pkg::MUL_P_W-1:0]   mul_p;
   logic [ROM_AW-1:0]             rom_addr;
   logic [fst_pkg::MAG_W-1:0]     rom_mag;

   logic [15:0]       total;
   logic [15:0]       remain;
   logic [6:0]        vol_sat;
   logic [IDX_W-1:0]  tbl_idx;
   logic [1:0]        quad;
   logic [IDX_W-1:0]  quad_off;
   logic [PROD_W-1:0] rem;
   logic [15:0]       mag;
   logic              out_free;
   logic              out_load;

   fst_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   fst_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .mag   (rom_mag)
   );

   // table index from the phase product, folded onto the quarter wave
   always_comb begin
      tbl_idx = mul_p[32 +: IDX_W];
      if (tbl_idx >= IDX_W'(3 * QUARTER_LEN)) begin
         quad     = 2'd3;
         quad_off = tbl_idx - IDX_W'(3 * QUARTER_LEN);
      end else if (tbl_idx >= IDX_W'(2 * QUARTER_LEN)) begin
         quad     = 2'd2;
         quad_off = tbl_idx - IDX_W'(2 * QUARTER_LEN);
      end else if (tbl_idx >= IDX_W'(QUARTER_LEN)) begin
         quad     = 2'd1;
         quad_off = tbl_idx - IDX_W'(QUARTER_LEN);
      end else begin
         quad     = 2'd0;
         quad_off = tbl_idx;
      end
      rom_addr = quad[0] ? ROM_AW'(QUARTER_LEN) - ROM_AW'(quad_off) : ROM_AW'(quad_off);
   end

   assign total    = {cfg.duration_ms, 4'b0000};
   assign remain   = total - idx_ff;
   assign vol_sat  = (cfg.volume_pct > 7'd100) ? 7'd100 : cfg.volume_pct;
   assign rem      = r_ff - mul_p[PROD_W-1:0];
   assign mag      = (rem >= PROD_W'(FADE_SAMPLES)) ? qest_ff + 16'd1 : qest_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      phase_in    = phase_ff;
      run_in      = run_ff;
      amp_in      = amp_ff;
      env_in      = env_ff;
      last_in     = last_ff;
      sign_in     = sign_ff;
      r_in        = r_ff;
      qest_in     = qest_ff;
      sample_in   = sample_ff;
      active_in   = active_ff;
      last_out_in = last_out_ff;
      out_load    = 1'b0;
      mul_en      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;

      unique case (state_ff)
         fst_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.start_req) begin
                  idx_in   = '0;
                  phase_in = '0;
                  run_in   = 1'b1;
               end
               state_in = fst_pkg::ST_EVAL;
            end
         end
         fst_pkg::ST_EVAL: begin
            if (!run_ff || idx_ff >= total) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  sample_in   = '0;
                  active_in   = 1'b0;
                  last_out_in = 1'b0;
                  run_in      = 1'b0;
                  state_in    = fst_pkg::ST_IDLE;
               end
            end else begin
               // 320 * volume as two shifted adds
               amp_in = (15'(vol_sat) << 8) + (15'(vol_sat) << 6);
               if (idx_ff < 16'(FADE_SAMPLES)) begin
                  env_in = ENV_W'(idx_ff);
               end else if (remain < 16'(FADE_SAMPLES)) begin
                  env_in = ENV_W'(remain);
               end else begin
                  env_in = ENV_W'(FADE_SAMPLES);
               end
               last_in  = (remain == 16'd1);
               state_in = fst_pkg::ST_IDX;
            end
         end
         fst_pkg::ST_IDX: begin
            mul_en   = 1'b1;
            mul_a    = phase_ff;
            mul_b    = fst_pkg::MUL_B_W'(SINE_TABLE_DEPTH);
            state_in = fst_pkg::ST_AE;
         end
         fst_pkg::ST_AE: begin
            sign_in  = quad[1];
            mul_en   = 1'b1;
            mul_a    = fst_pkg::MUL_A_W'(amp_ff);
            mul_b    = fst_pkg::MUL_B_W'(env_ff);
            state_in = fst_pkg::ST_PS;
         end
         fst_pkg::ST_PS: begin
            mul_en   = 1'b1;
            mul_a    = fst_pkg::MUL_A_W'(mul_p[PROD_W-1:0]);
            mul_b    = fst_pkg::MUL_B_W'(rom_mag);
            state_in = fst_pkg::ST_DIV;
         end
         fst_pkg::ST_DIV: begin
            r_in     = mul_p[15 +: PROD_W];
            mul_en   = 1'b1;
            mul_a    = fst_pkg::MUL_A_W'(r_in);
            mul_b    = fst_pkg::MUL_B_W'(RECIP);
            state_in = fst_pkg::ST_QF;
         end
         fst_pkg::ST_QF: begin
            qest_in  = mul_p[PROD_W +: 16];
            mul_en   = 1'b1;
            mul_a    = fst_pkg::MUL_A_W'(qest_in);
            mul_b    = fst_pkg::MUL_B_W'(FADE_SAMPLES);
            state_in = fst_pkg::ST_FIX;
         end
         fst_pkg::ST_FIX: begin
            if (out_free) begin
               out_load    = 1'b1;
               sample_in   = sign_ff ? 16'd0 - mag : mag;
               active_in   = 1'b1;
               last_out_in = last_ff;
               idx_in      = idx_ff + 16'd1;
               phase_in    = phase_ff + cfg.phase_step;
               if (last_ff) begin
                  run_in = 1'b0;
               end
               state_in = fst_pkg::ST_IDLE;
            end
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         phase_ff     <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_ff      <= amp_in;
      env_ff      <= env_in;
      last_ff     <= last_in;
      sign_ff     <= sign_in;
      r_ff        <= r_in;
      qest_ff     <= qest_in;
      sample_ff   <= sample_in;
      active_ff   <= active_in;
      last_out_ff <= last_out_in;
   end

   assign req_ch.ready  = (state_ff == fst_pkg::ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = $signed(sample_ff);
   assign rsp_ch.active = active_ff;
   assign rsp_ch.last   = last_out_ff;

   `FST_ASSERT_IMPL(a_idle_beat_zero, rsp_ch.valid && !rsp_ch.active, (rsp_ch.sample == 16'sd0) && !rsp_ch.last, "idle beat with nonzero sample or last")
   `FST_ASSERT_IMPL(a_sample_range, rsp_ch.valid, (rsp_ch.sample <= 16'sd32000) && (rsp_ch.sample >= -16'sd32000), "sample beyond peak amplitude")
   `FST_ASSERT_NEXT(a_last_ends_burst, out_load && last_out_in, !run_ff, "burst still running after its last sample")
   `FST_ASSERT_IMPL(a_quotient_close, state_ff == fst_pkg::ST_FIX, rem < TWO_FADE, "reciprocal quotient off by more than one")

endmodule

// ===== rtl/faded_sine_tone_burst_top.sv =====
// top level of the faded sine tone burst generator
// Faded sine tone burst generator. Every req_ch beat is one 16 kHz tick and yields exactly
// one rsp_ch beat: start_req high restarts the burst at sample zero, low advances it. A burst
// is 16 * duration_ms samples of 320 * volume_pct * envelope * sine(phase), with the phase
// stepped by phase_step each sample, a linear fade over the first and last FADE_SAMPLES
// samples and a SINE_TABLE_DEPTH-entry q1.15 sine read from a quarter-wave table; outside a
// burst the sample is zero with active low. A running sample steps through the eval, index,
// amplitude, product, divide, quotient and fix states to its response beat, an idle tick
// from eval to it: the sequencer feeds one shared 32 x 16 multiplier five times per sample
// (phase to table index, amplitude by envelope, by the sine magnitude, then a reciprocal
// divide by the fade length and its check), with the table read in between. req_ch.ready is
// high only while the sequencer is between samples; a finished sample sits in the response
// register until it is taken, and the sequencer waits on it before writing the next one.
// Registers are written through csr_ch (index 0 phase_step, 1 duration_ms, 2 volume_pct,
// other indexes ignored), always ready; changes apply from the next sample.
module faded_sine_tone_burst_top #(
   parameter int SINE_TABLE_DEPTH = fst_pkg::DEF_SINE_TABLE_DEPTH,
   parameter int FADE_SAMPLES     = fst_pkg::DEF_FADE_SAMPLES
) (
   input  logic      clock,
   input  logic      reset,
   fst_req_if.sink   req_ch,
   fst_rsp_if.source rsp_ch,
   fst_csr_if.sink   csr_ch
);

   // configuration registers, cleared by reset
   logic [31:0]      phase_step_ff;
   logic [11:0]      duration_ms_ff;
   logic [6:0]       volume_pct_ff;
   fst_pkg::cfg_type cfg;

   // register writes land on every beat, never stalled
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         duration_ms_ff <= '0;
         volume_pct_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            fst_pkg::CSR_PHASE_STEP:  phase_step_ff  <= csr_ch.data;
            fst_pkg::CSR_DURATION_MS: duration_ms_ff <= csr_ch.data[11:0];
            fst_pkg::CSR_VOLUME_PCT:  volume_pct_ff  <= csr_ch.data[6:0];
            default: ;
         endcase
      end
   end

   // register view handed to the sequencer
   assign cfg.phase_step  = phase_step_ff;
   assign cfg.duration_ms = duration_ms_ff;
   assign cfg.volume_pct  = volume_pct_ff;

   // sequencer with the shared multiplier and the sine table
   fst_seq #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .FADE_SAMPLES     (FADE_SAMPLES)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
